FILE: hdl/x86alu_pkg.sv
// ---------------------------------------------------------------------------
// x86alu_pkg
// types and codes shared by the 16-bit x86 alu with flags
// ---------------------------------------------------------------------------
package x86alu_pkg;

	localparam logic [4:0] MODE_ADD  = 5'd0;
	localparam logic [4:0] MODE_ADC  = 5'd1;
	localparam logic [4:0] MODE_SUB  = 5'd2;
	localparam logic [4:0] MODE_SBB  = 5'd3;
	localparam logic [4:0] MODE_AND  = 5'd4;
	localparam logic [4:0] MODE_OR   = 5'd5;
	localparam logic [4:0] MODE_XOR  = 5'd6;
	localparam logic [4:0] MODE_CMP  = 5'd7;
	localparam logic [4:0] MODE_TEST = 5'd8;
	localparam logic [4:0] MODE_INC  = 5'd9;
	localparam logic [4:0] MODE_DEC  = 5'd10;
	localparam logic [4:0] MODE_NEG  = 5'd11;
	localparam logic [4:0] MODE_NOT  = 5'd12;
	localparam logic [4:0] MODE_ROL  = 5'd13;
	localparam logic [4:0] MODE_ROR  = 5'd14;
	localparam logic [4:0] MODE_RCL  = 5'd15;
	localparam logic [4:0] MODE_RCR  = 5'd16;
	localparam logic [4:0] MODE_SHL  = 5'd17;
	localparam logic [4:0] MODE_SHR  = 5'd18;
	localparam logic [4:0] MODE_SAR  = 5'd19;
	localparam logic [4:0] MODE_MUL  = 5'd20;
	localparam logic [4:0] MODE_IMUL = 5'd21;
	localparam logic [4:0] MODE_DIV  = 5'd22;
	localparam logic [4:0] MODE_IDIV = 5'd23;
	localparam logic [4:0] MODE_DAA  = 5'd24;
	localparam logic [4:0] MODE_DAS  = 5'd25;
	localparam logic [4:0] MODE_AAA  = 5'd26;
	localparam logic [4:0] MODE_AAS  = 5'd27;
	localparam logic [4:0] MODE_AAM  = 5'd28;
	localparam logic [4:0] MODE_AAD  = 5'd29;
	localparam logic [4:0] MODE_LDF  = 5'd30;
	localparam logic [4:0] MODE_NOP  = 5'd31;

	localparam int F_CF = 0;
	localparam int F_PF = 1;
	localparam int F_AF = 2;
	localparam int F_ZF = 3;
	localparam int F_SF = 4;
	localparam int F_OF = 5;

	typedef struct packed {
		logic [4:0]  mode;
		logic        wide;
		logic [31:0] operand_a;
		logic [15:0] operand_b;
		logic [7:0]  shift_count;
	} req_t;

	typedef struct packed {
		logic [15:0] result_main;
		logic [15:0] result_extra;
		logic        carry_flag;
		logic        parity_flag;
		logic        aux_flag;
		logic        zero_flag;
		logic        sign_flag;
		logic        overflow_flag;
		logic        divide_error;
	} rsp_t;

endpackage

FILE: hdl/x86_16bit_alu_with_flags.sv
// ---------------------------------------------------------------------------
// x86_16bit_alu_with_flags
// 8086-style alu: one operation per beat, keeps CF PF AF ZF SF OF
// ---------------------------------------------------------------------------
// One beat in, one beat out. The block takes a beat only when idle and holds
// req_stall high until its result sits in the output register. Shifts and
// rotates step one bit per cycle through a shared shifter when the count is
// nonzero (count masked to 5 bits). Divides and AAM run a restoring divider
// one quotient bit per cycle; a zero divisor skips the divider and flags a
// divide error. The output register frees the pipe while a result waits.
module x86_16bit_alu_with_flags (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  x86alu_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output x86alu_pkg::rsp_t   rsp
);

	typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_DIV, S_FIN} state_t;

	state_t      state_q;
	logic [5:0]  flags_q;
	logic [4:0]  op_q;
	logic        w_q;
	logic [15:0] main_q;
	logic [15:0] extra_q;
	logic [5:0]  nf_q;
	logic        err_q;
	logic [31:0] wx_q;
	logic [15:0] rem_q;
	logic [15:0] mb_q;
	logic        na_q;
	logic        nb_q;
	logic        cf_q;
	logic        of_q;
	logic [5:0]  cnt_q;
	logic        rsp_valid_q;
	x86alu_pkg::rsp_t rsp_q;

	function automatic logic [5:0] szp(input logic [15:0] r, input logic w,
			input logic [5:0] fi);
		logic [5:0] f;
		f = fi;
		f[x86alu_pkg::F_SF] = w ? r[15] : r[7];
		f[x86alu_pkg::F_ZF] = (r == 16'h0000);
		f[x86alu_pkg::F_PF] = ~^r[7:0];
		return f;
	endfunction

	function automatic logic [21:0] add_core(input logic [15:0] x, input logic [15:0] y,
			input logic c, input logic sub, input logic w, input logic [5:0] fi);
		logic [16:0] t;
		logic [15:0] r;
		logic [5:0]  f;
		f = fi;
		if (sub) begin
			t = {1'b0, x} - {1'b0, y} - {16'h0000, c};
		end else begin
			t = {1'b0, x} + {1'b0, y} + {16'h0000, c};
		end
		r = w ? t[15:0] : {8'h00, t[7:0]};
		f[x86alu_pkg::F_AF] = x[4] ^ y[4] ^ t[4];
		if (sub) begin
			f[x86alu_pkg::F_CF] = t[16];
			f[x86alu_pkg::F_OF] = w ? ((x[15] ^ y[15]) & (x[15] ^ t[15]))
			                        : ((x[7] ^ y[7]) & (x[7] ^ t[7]));
		end else begin
			f[x86alu_pkg::F_CF] = w ? t[16] : t[8];
			f[x86alu_pkg::F_OF] = w ? ((t[15] ^ x[15]) & (t[15] ^ y[15]))
			                        : ((t[7] ^ x[7]) & (t[7] ^ y[7]));
		end
		f = szp(r, w, f);
		return {f, r};
	endfunction

	// operand selection
	logic [15:0] x, y;
	logic [7:0]  al, ah, b8;
	logic        w;
	assign w  = req.wide;
	assign x  = w ? req.operand_a[15:0] : {8'h00, req.operand_a[7:0]};
	assign y  = w ? req.operand_b : {8'h00, req.operand_b[7:0]};
	assign al = req.operand_a[7:0];
	assign ah = req.operand_a[15:8];
	assign b8 = req.operand_b[7:0];

	// shared adder and multiplier
	logic [15:0] ax, ay;
	logic        ac, asub, aw;
	logic [21:0] add_o;
	logic [16:0] mx, my;
	logic [33:0] prod;
	logic [31:0] p32;
	logic        daa_lo, daa_hi;

	assign daa_lo = (al[3:0] > 4'd9) || flags_q[x86alu_pkg::F_AF];
	assign daa_hi = (al > 8'h99) || flags_q[x86alu_pkg::F_CF];

	always_comb begin
		ax = x;
		ay = y;
		ac = 1'b0;
		asub = 1'b0;
		aw = w;
		unique case (req.mode) inside
			x86alu_pkg::MODE_ADC: ac = flags_q[x86alu_pkg::F_CF];
			x86alu_pkg::MODE_SUB, x86alu_pkg::MODE_CMP: asub = 1'b1;
			x86alu_pkg::MODE_SBB: begin
				asub = 1'b1;
				ac = flags_q[x86alu_pkg::F_CF];
			end
			x86alu_pkg::MODE_INC: ay = 16'h0001;
			x86alu_pkg::MODE_DEC: begin
				ay = 16'h0001;
				asub = 1'b1;
			end
			x86alu_pkg::MODE_NEG: begin
				ax = 16'h0000;
				ay = x;
				asub = 1'b1;
			end
			x86alu_pkg::MODE_DAA, x86alu_pkg::MODE_DAS: begin
				ax = {8'h00, al};
				ay = {8'h00, daa_hi ? 4'h6 : 4'h0, daa_lo ? 4'h6 : 4'h0};
				asub = (req.mode == x86alu_pkg::MODE_DAS);
				aw = 1'b0;
			end
			x86alu_pkg::MODE_AAD: begin
				ax = {8'h00, al};
				ay = {8'h00, p32[7:0]};
				aw = 1'b0;
			end
			default: ;
		endcase
	end

	assign add_o = add_core(ax, ay, ac, asub, aw, flags_q);

	always_comb begin
		mx = {1'b0, x};
		my = {1'b0, y};
		unique case (req.mode) inside
			x86alu_pkg::MODE_IMUL: begin
				mx = w ? {x[15], x} : {{9{x[7]}}, x[7:0]};
				my = w ? {y[15], y} : {{9{y[7]}}, y[7:0]};
			end
			x86alu_pkg::MODE_AAD: begin
				mx = {9'h000, ah};
				my = {9'h000, b8};
			end
			default: ;
		endcase
	end

	assign prod = $signed(mx) * $signed(my);
	assign p32  = prod[31:0];

	// plain operations and iteration set-up
	logic [15:0] s_main, s_extra;
	logic [5:0]  s_f;
	logic        s_err, s_go_shift, s_go_div;
	logic [7:0]  al2, ah2;
	logic        a_cond;
	logic [15:0] a16_neg;
	logic [31:0] a32_neg;
	logic [15:0] b_neg;

	assign a_cond  = (al[3:0] > 4'd9) || flags_q[x86alu_pkg::F_AF];
	assign a16_neg = 16'h0000 - req.operand_a[15:0];
	assign a32_neg = 32'h00000000 - req.operand_a;
	assign b_neg   = 16'h0000 - y;

	always_comb begin
		s_main = 16'h0000;
		s_extra = 16'h0000;
		s_f = flags_q;
		s_err = 1'b0;
		s_go_shift = 1'b0;
		s_go_div = 1'b0;
		al2 = al;
		ah2 = ah;
		unique case (req.mode) inside
			x86alu_pkg::MODE_ADD, x86alu_pkg::MODE_ADC, x86alu_pkg::MODE_SUB,
			x86alu_pkg::MODE_SBB, x86alu_pkg::MODE_NEG: begin
				s_main = add_o[15:0];
				s_f = add_o[21:16];
			end
			x86alu_pkg::MODE_CMP: begin
				s_main = x;
				s_f = add_o[21:16];
			end
			x86alu_pkg::MODE_INC, x86alu_pkg::MODE_DEC: begin
				s_main = add_o[15:0];
				s_f = add_o[21:16];
				s_f[x86alu_pkg::F_CF] = flags_q[x86alu_pkg::F_CF];
			end
			x86alu_pkg::MODE_AND, x86alu_pkg::MODE_OR, x86alu_pkg::MODE_XOR,
			x86alu_pkg::MODE_TEST: begin
				unique case (req.mode) inside
					x86alu_pkg::MODE_OR:  s_main = x | y;
					x86alu_pkg::MODE_XOR: s_main = x ^ y;
					default:              s_main = x & y;
				endcase
				s_f[x86alu_pkg::F_CF] = 1'b0;
				s_f[x86alu_pkg::F_OF] = 1'b0;
				s_f[x86alu_pkg::F_AF] = 1'b0;
				s_f = szp(s_main, w, s_f);
				if (req.mode == x86alu_pkg::MODE_TEST) begin
					s_main = x;
				end
			end
			x86alu_pkg::MODE_NOT: s_main = w ? ~x : {8'h00, ~x[7:0]};
			x86alu_pkg::MODE_ROL, x86alu_pkg::MODE_ROR, x86alu_pkg::MODE_RCL,
			x86alu_pkg::MODE_RCR, x86alu_pkg::MODE_SHL, x86alu_pkg::MODE_SHR,
			x86alu_pkg::MODE_SAR: begin
				s_main = x;
				s_go_shift = (req.shift_count[4:0] != 5'd0);
			end
			x86alu_pkg::MODE_MUL: begin
				s_main = p32[15:0];
				s_extra = w ? p32[31:16] : 16'h0000;
				s_f[x86alu_pkg::F_CF] = w ? |p32[31:16] : |p32[15:8];
				s_f[x86alu_pkg::F_OF] = s_f[x86alu_pkg::F_CF];
			end
			x86alu_pkg::MODE_IMUL: begin
				s_main = p32[15:0];
				s_extra = w ? p32[31:16] : 16'h0000;
				s_f[x86alu_pkg::F_CF] = w ? !((&p32[31:15]) || !(|p32[31:15]))
				                          : !((&p32[31:7]) || !(|p32[31:7]));
				s_f[x86alu_pkg::F_OF] = s_f[x86alu_pkg::F_CF];
			end
			x86alu_pkg::MODE_DIV, x86alu_pkg::MODE_IDIV: begin
				s_err = (y == 16'h0000);
				s_go_div = !s_err;
			end
			x86alu_pkg::MODE_DAA, x86alu_pkg::MODE_DAS: begin
				s_f = add_o[21:16];
				s_f[x86alu_pkg::F_AF] = daa_lo;
				s_f[x86alu_pkg::F_CF] = daa_hi;
				s_main = {ah, add_o[7:0]};
			end
			x86alu_pkg::MODE_AAA, x86alu_pkg::MODE_AAS: begin
				if (req.mode == x86alu_pkg::MODE_AAA) begin
					s_f[x86alu_pkg::F_SF] = (al >= 8'h7A) && (al <= 8'hF9);
					s_f[x86alu_pkg::F_OF] = (al >= 8'h7A) && (al <= 8'h7F);
				end else begin
					s_f[x86alu_pkg::F_SF] = (!flags_q[x86alu_pkg::F_AF] && (al > 8'h7F)) ||
						(flags_q[x86alu_pkg::F_AF] && ((al <= 8'h05) || (al >= 8'h86)));
					s_f[x86alu_pkg::F_OF] = flags_q[x86alu_pkg::F_AF] && (al > 8'h7F) &&
						(al <= 8'h85);
				end
				if (a_cond) begin
					al2 = (req.mode == x86alu_pkg::MODE_AAA) ? al + 8'h06 : al - 8'h06;
					ah2 = (req.mode == x86alu_pkg::MODE_AAA) ? ah + 8'h01 : ah - 8'h01;
				end
				s_f[x86alu_pkg::F_AF] = a_cond;
				s_f[x86alu_pkg::F_CF] = a_cond;
				s_f[x86alu_pkg::F_ZF] = (al2 == 8'h00);
				s_f[x86alu_pkg::F_PF] = ~^al2;
				s_main = {ah2, 4'h0, al2[3:0]};
			end
			x86alu_pkg::MODE_AAM: begin
				if (b8 == 8'h00) begin
					s_f = 6'b000000;
					s_err = 1'b1;
				end else begin
					s_go_div = 1'b1;
				end
			end
			x86alu_pkg::MODE_AAD: begin
				s_f = add_o[21:16];
				s_f[x86alu_pkg::F_AF] = 1'b0;
				s_f[x86alu_pkg::F_CF] = 1'b0;
				s_f[x86alu_pkg::F_OF] = 1'b0;
				s_main = {8'h00, add_o[7:0]};
			end
			x86alu_pkg::MODE_LDF: begin
				s_f[x86alu_pkg::F_CF] = req.operand_b[0];
				s_f[x86alu_pkg::F_PF] = req.operand_b[2];
				s_f[x86alu_pkg::F_AF] = req.operand_b[4];
				s_f[x86alu_pkg::F_ZF] = req.operand_b[6];
				s_f[x86alu_pkg::F_SF] = req.operand_b[7];
				s_f[x86alu_pkg::F_OF] = req.operand_b[11];
			end
			default: ;
		endcase
	end

	// shared one-bit shifter
	logic [15:0] sx, sh_x, sh_mbit;
	logic        sh_msb, sh_cf, sh_of;
	logic [5:0]  sh_f;
	assign sx      = wx_q[15:0];
	assign sh_msb  = w_q ? sx[15] : sx[7];
	assign sh_mbit = w_q ? 16'h8000 : 16'h0080;

	always_comb begin
		sh_cf = cf_q;
		sh_of = of_q;
		sh_x = sx;
		case (op_q)
			x86alu_pkg::MODE_ROL: begin
				sh_cf = sh_msb;
				sh_x = {sx[14:0], sh_msb};
			end
			x86alu_pkg::MODE_ROR: begin
				sh_cf = sx[0];
				sh_x = (sx >> 1) | (sx[0] ? sh_mbit : 16'h0000);
			end
			x86alu_pkg::MODE_RCL: begin
				sh_cf = sh_msb;
				sh_x = {sx[14:0], cf_q};
			end
			x86alu_pkg::MODE_RCR: begin
				sh_cf = sx[0];
				sh_x = (sx >> 1) | (cf_q ? sh_mbit : 16'h0000);
			end
			x86alu_pkg::MODE_SHL: begin
				sh_cf = sh_msb;
				sh_x = {sx[14:0], 1'b0};
			end
			x86alu_pkg::MODE_SHR: begin
				sh_of = sh_msb;
				sh_cf = sx[0];
				sh_x = sx >> 1;
			end
			default: begin
				sh_cf = sx[0];
				sh_x = (sx >> 1) | (sx & sh_mbit);
			end
		endcase
		if (!w_q) begin
			sh_x[15:8] = 8'h00;
		end
	end

	always_comb begin
		sh_f = nf_q;
		sh_f[x86alu_pkg::F_CF] = cf_q;
		case (op_q)
			x86alu_pkg::MODE_ROL, x86alu_pkg::MODE_RCL, x86alu_pkg::MODE_SHL:
				sh_f[x86alu_pkg::F_OF] = sh_msb ^ cf_q;
			x86alu_pkg::MODE_ROR, x86alu_pkg::MODE_RCR:
				sh_f[x86alu_pkg::F_OF] = sh_msb ^ (w_q ? sx[14] : sx[6]);
			x86alu_pkg::MODE_SHR: sh_f[x86alu_pkg::F_OF] = of_q;
			default: sh_f[x86alu_pkg::F_OF] = 1'b0;
		endcase
		if (op_q >= x86alu_pkg::MODE_SHL) begin
			sh_f[x86alu_pkg::F_AF] = (op_q == x86alu_pkg::MODE_SHL) ? sx[4] : 1'b1;
			sh_f = szp(sx, w_q, sh_f);
		end
	end

	// shared restoring divider step and sign fix-up
	logic [16:0] dv_rs;
	logic        dv_ge;
	logic [15:0] dv_rem;
	logic [31:0] dv_msb, dv_mask, dv_q;
	logic [15:0] dv_r;
	logic        dv_err;
	logic [5:0]  dv_f;

	assign dv_rs   = {rem_q, wx_q[31]};
	assign dv_ge   = dv_rs >= {1'b0, mb_q};
	assign dv_rem  = dv_ge ? 16'(dv_rs - {1'b0, mb_q}) : dv_rs[15:0];
	assign dv_msb  = w_q ? 32'h00008000 : 32'h00000080;
	assign dv_mask = w_q ? 32'h0000FFFF : 32'h000000FF;

	always_comb begin
		dv_q = wx_q;
		dv_r = rem_q;
		dv_err = 1'b0;
		dv_f = nf_q;
		if (op_q == x86alu_pkg::MODE_AAM) begin
			dv_f = szp({8'h00, rem_q[7:0]}, 1'b0, dv_f);
			dv_f[x86alu_pkg::F_AF] = 1'b0;
			dv_f[x86alu_pkg::F_CF] = 1'b0;
			dv_f[x86alu_pkg::F_OF] = 1'b0;
			dv_q = {16'h0000, wx_q[7:0], rem_q[7:0]};
			dv_r = 16'h0000;
		end else if (op_q == x86alu_pkg::MODE_IDIV) begin
			if (na_q != nb_q) begin
				dv_err = wx_q > dv_msb;
				dv_q = 32'h00000000 - wx_q;
			end else begin
				dv_err = wx_q > (dv_msb - 32'h00000001);
			end
			if (na_q) begin
				dv_r = 16'h0000 - rem_q;
			end
		end else begin
			dv_err = wx_q > dv_mask;
		end
		if (op_q != x86alu_pkg::MODE_AAM) begin
			dv_q = dv_q & dv_mask;
			dv_r = dv_r & dv_mask[15:0];
		end
		if (dv_err) begin
			dv_q = 32'h00000000;
			dv_r = 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flags_q <= 6'b000000;
			rsp_valid_q <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q <= req.mode;
						w_q <= w;
						main_q <= s_main;
						extra_q <= s_extra;
						nf_q <= s_f;
						err_q <= s_err;
						cf_q <= flags_q[x86alu_pkg::F_CF];
						of_q <= flags_q[x86alu_pkg::F_OF];
						rem_q <= 16'h0000;
						na_q <= 1'b0;
						nb_q <= 1'b0;
						if (s_go_shift) begin
							wx_q <= {16'h0000, x};
							cnt_q <= {1'b0, req.shift_count[4:0]};
							state_q <= S_SHIFT;
						end else if (s_go_div) begin
							state_q <= S_DIV;
							if (req.mode == x86alu_pkg::MODE_AAM) begin
								wx_q <= {8'h00, al, 16'h0000};
								mb_q <= {8'h00, b8};
								cnt_q <= 6'd16;
							end else if (w) begin
								na_q <= (req.mode == x86alu_pkg::MODE_IDIV) &&
									req.operand_a[31];
								nb_q <= (req.mode == x86alu_pkg::MODE_IDIV) && y[15];
								wx_q <= ((req.mode == x86alu_pkg::MODE_IDIV) &&
									req.operand_a[31]) ? a32_neg : req.operand_a;
								mb_q <= ((req.mode == x86alu_pkg::MODE_IDIV) && y[15]) ?
									b_neg : y;
								cnt_q <= 6'd32;
							end else begin
								na_q <= (req.mode == x86alu_pkg::MODE_IDIV) &&
									req.operand_a[15];
								nb_q <= (req.mode == x86alu_pkg::MODE_IDIV) && y[7];
								wx_q <= {((req.mode == x86alu_pkg::MODE_IDIV) &&
									req.operand_a[15]) ? a16_neg : req.operand_a[15:0],
									16'h0000};
								mb_q <= ((req.mode == x86alu_pkg::MODE_IDIV) && y[7]) ?
									{8'h00, b_neg[7:0]} : y;
								cnt_q <= 6'd16;
							end
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SHIFT: begin
					if (cnt_q == 6'd0) begin
						main_q <= sx;
						nf_q <= sh_f;
						state_q <= S_FIN;
					end else begin
						wx_q <= {16'h0000, sh_x};
						cf_q <= sh_cf;
						of_q <= sh_of;
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						main_q <= dv_q[15:0];
						extra_q <= dv_r;
						err_q <= dv_err;
						nf_q <= dv_f;
						state_q <= S_FIN;
					end else begin
						rem_q <= dv_rem;
						wx_q <= {wx_q[30:0], dv_ge};
						cnt_q <= cnt_q - 6'd1;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						rsp_q.result_main <= main_q;
						rsp_q.result_extra <= extra_q;
						rsp_q.carry_flag <= nf_q[x86alu_pkg::F_CF];
						rsp_q.parity_flag <= nf_q[x86alu_pkg::F_PF];
						rsp_q.aux_flag <= nf_q[x86alu_pkg::F_AF];
						rsp_q.zero_flag <= nf_q[x86alu_pkg::F_ZF];
						rsp_q.sign_flag <= nf_q[x86alu_pkg::F_SF];
						rsp_q.overflow_flag <= nf_q[x86alu_pkg::F_OF];
						rsp_q.divide_error <= err_q;
						flags_q <= nf_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
